### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bfpf_pkg.sv
// ---------------------------------------------------------------------------
// Frame parser package
// Codes, widths and the result type shared by the frame parser modules.
// ---------------------------------------------------------------------------
package bfpf_pkg;

  localparam logic [7:0]  SyncFirst    = 8'hB5;
  localparam logic [7:0]  SyncSecond   = 8'h62;
  localparam logic [15:0] CountMax     = 16'hFFFF;
  localparam logic [15:0] MaxLenReset  = 16'd1024;

  // parser phases
  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhClass   = 3'd1;
  localparam logic [2:0] PhId      = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhLenHi   = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;
  localparam logic [2:0] PhCkA     = 3'd6;
  localparam logic [2:0] PhCkB     = 3'd7;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_CK_ERR  = 3'd3,
    EV_LEN_ERR = 3'd4
  } event_e;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic [15:0] error_total;
    logic [15:0] frame_total;
  } result_t;

endpackage

### rtl/core/bfpf_parser.sv
// ---------------------------------------------------------------------------
// Frame parser datapath
// Per-byte phase step, Fletcher update and counters; one byte per cycle while accept_i is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfpf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       max_len_i,
  output bfpf_pkg::result_t result_o
);

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  last_q, last_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  ck_a_q, ck_a_d;
  logic [15:0] err_q, err_d;
  logic [15:0] frm_q, frm_d;

  logic [7:0]  fold_a;
  logic [7:0]  fold_b;
  logic [15:0] len_full;
  logic [16:0] pos_next;
  logic [15:0] err_inc;
  logic [15:0] frm_inc;
  bfpf_pkg::event_e ev;
  logic [15:0] pidx;
  logic [7:0]  pbyte;

  assign fold_a   = sum_a_q + byte_i;
  assign fold_b   = sum_b_q + fold_a;
  assign len_full = {byte_i, len_q[7:0]};
  assign pos_next = {1'b0, pos_q} + 17'd1;
  assign err_inc  = (err_q != bfpf_pkg::CountMax) ? err_q + 16'd1 : err_q;
  assign frm_inc  = (frm_q != bfpf_pkg::CountMax) ? frm_q + 16'd1 : frm_q;

  always_comb begin
    phase_d = phase_q;
    last_d  = byte_i;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    pos_d   = pos_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    ck_a_d  = ck_a_q;
    err_d   = err_q;
    frm_d   = frm_q;
    ev      = bfpf_pkg::EV_NONE;
    pidx    = '0;
    pbyte   = '0;
    case (phase_q)
      bfpf_pkg::PhHunt: begin
        if (byte_i == bfpf_pkg::SyncSecond && last_q == bfpf_pkg::SyncFirst) begin
          phase_d = bfpf_pkg::PhClass;
          class_d = '0;
          id_d    = '0;
          len_d   = '0;
          pos_d   = '0;
          sum_a_d = '0;
          sum_b_d = '0;
          ck_a_d  = '0;
        end
      end
      bfpf_pkg::PhClass: begin
        class_d = byte_i;
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        phase_d = bfpf_pkg::PhId;
      end
      bfpf_pkg::PhId: begin
        id_d    = byte_i;
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        phase_d = bfpf_pkg::PhLenLo;
      end
      bfpf_pkg::PhLenLo: begin
        len_d   = {8'd0, byte_i};
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        phase_d = bfpf_pkg::PhLenHi;
      end
      bfpf_pkg::PhLenHi: begin
        len_d   = len_full;
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        pos_d   = '0;
        if (len_full > max_len_i) begin
          err_d   = err_inc;
          ev      = bfpf_pkg::EV_LEN_ERR;
          phase_d = bfpf_pkg::PhHunt;
        end else if (len_full == 16'd0) begin
          phase_d = bfpf_pkg::PhCkA;
        end else begin
          phase_d = bfpf_pkg::PhPayload;
        end
      end
      bfpf_pkg::PhPayload: begin
        sum_a_d = fold_a;
        sum_b_d = fold_b;
        ev      = bfpf_pkg::EV_PAYLOAD;
        pidx    = pos_q;
        pbyte   = byte_i;
        if (pos_next >= {1'b0, len_q}) begin
          phase_d = bfpf_pkg::PhCkA;
        end
        pos_d   = pos_next[15:0];
      end
      bfpf_pkg::PhCkA: begin
        ck_a_d  = byte_i;
        phase_d = bfpf_pkg::PhCkB;
      end
      default: begin
        if (ck_a_q == sum_a_q && byte_i == sum_b_q) begin
          frm_d = frm_inc;
          ev    = bfpf_pkg::EV_GOOD;
        end else begin
          err_d = err_inc;
          ev    = bfpf_pkg::EV_CK_ERR;
        end
        phase_d = bfpf_pkg::PhHunt;
      end
    endcase
  end

  always_comb begin
    result_o.event_res     = ev;
    result_o.frame_class   = class_d;
    result_o.frame_id      = id_d;
    result_o.frame_length  = len_d;
    result_o.payload_index = pidx;
    result_o.payload_byte  = pbyte;
    result_o.error_total   = err_d;
    result_o.frame_total   = frm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bfpf_pkg::PhHunt;
      last_q  <= '0;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      ck_a_q  <= '0;
      err_q   <= '0;
      frm_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      last_q  <= last_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      ck_a_q  <= ck_a_d;
      err_q   <= err_d;
      frm_q   <= frm_d;
    end
  end

  // while in the payload the position never reaches the length
  `ASSERT_IMPL(a_pos_in_range, phase_q == bfpf_pkg::PhPayload, pos_q < len_q,
               "payload position past frame length")
  // counters only ever grow
  `ASSERT_NEXT(a_counts_grow, 1'b1, err_q >= $past(err_q) && frm_q >= $past(frm_q),
               "error or frame counter went backwards")

endmodule

### rtl/core/bfpf_skid.sv
// ---------------------------------------------------------------------------
// Result output buffer
// Output register plus skid register; ready is taken from a flop.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bfpf_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  bfpf_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output bfpf_pkg::result_t data_o,
  input  logic              ready_i
);

  logic              main_valid_q;
  logic              skid_valid_q;
  bfpf_pkg::result_t main_q;
  bfpf_pkg::result_t skid_q;
  logic              take;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  assign take    = valid_i && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= valid_i;
      end
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : data_i;
    end else if (take) begin
      skid_q <= data_i;
    end
  end

  `ASSERT_ALWAYS(a_skid_behind_main, !skid_valid_q || main_valid_q,
                 "skid entry held with empty output register")
  `ASSERT_NEXT(a_stall_holds, valid_o && !ready_i, valid_o && $stable(data_o),
               "output transaction changed while stalled")

endmodule

### rtl/core/binary_frame_parser_fletcher.sv
// ---------------------------------------------------------------------------
// Binary frame parser with Fletcher-8 checksum
// Byte-serial sync/header/payload parser with running checksum and counters.
// ---------------------------------------------------------------------------
// Feed one received byte per input transaction; every byte yields exactly one
// registered result transaction. The block takes a byte in every cycle while
// its skid register is empty: the phase step, the 8-bit Fletcher update and
// the counters sit between the input handshake and the output register, and a
// two-entry output buffer keeps s_axis_tready high until a downstream stall fills it.
// The parser hunts for 0xB5 0x62, then reads class, id, a little-endian
// length, the payload and checksum bytes A and B. Each payload byte comes out
// with its index (event 1); a frame ends as good (2) or checksum error (3).
// A length above max_payload_length gives event 4 and a return to hunting;
// a zero length goes straight to the checksum. Error and good-frame counters
// saturate at 65535. Write max_payload_length (reset 1024) only while idle.
// ---------------------------------------------------------------------------
module binary_frame_parser_fletcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [7:0] frame_class, [15:8] frame_id,
                                      // [31:16] frame_length, [47:32] payload_index,
                                      // [55:48] payload_byte, [71:56] error_total,
                                      // [87:72] frame_total
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  // max_payload_length write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]       max_len_q;
  logic              in_accept;
  bfpf_pkg::result_t step_res;
  bfpf_pkg::result_t out_res;

  // register writes always complete at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= bfpf_pkg::MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // advance the parser state on every accepted byte
  bfpf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .byte_i    (s_axis_tdata),
    .max_len_i (max_len_q),
    .result_o  (step_res)
  );

  // hold results until the downstream side takes them
  bfpf_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .data_i  (step_res),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tuser = out_res.event_res;
  assign m_axis_tdata = {out_res.frame_total, out_res.error_total, out_res.payload_byte,
                         out_res.payload_index, out_res.frame_length, out_res.frame_id,
                         out_res.frame_class};

endmodule
